FILE: rtl/core/ordered_array_insert_erase_macros.svh
// ----------------------------------------------------------------------------
// ordered_array_insert_erase_macros
// assertion macros used by the ordered array rtl
// ----------------------------------------------------------------------------
`ifndef ORDERED_ARRAY_INSERT_ERASE_MACROS_SVH
`define ORDERED_ARRAY_INSERT_ERASE_MACROS_SVH

// same-cycle implication
`define OAIE_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define OAIE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/oaie_pkg.sv
// ----------------------------------------------------------------------------
// oaie_pkg
// types and constants of the ordered array with insert and erase
// ----------------------------------------------------------------------------
package oaie_pkg;

   localparam int CAPACITY    = 64;
   localparam int DATA_WIDTH  = 32;
   localparam int IDX_W       = $clog2(CAPACITY);
   localparam int CNT_W       = $clog2(CAPACITY + 1);
   localparam int INDEX_W     = 6;
   localparam int VALUE_W     = 32;
   localparam int READ_DATA_W = 32;
   localparam int COUNT_W     = 7;
   localparam int STATUS_W    = 2;
   // compare width that holds both a request index and the fill count
   localparam int CMP_W       = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

   typedef enum logic [2:0] {
      OP_APPEND      = 3'd0,
      OP_REMOVE_LAST = 3'd1,
      OP_INSERT      = 3'd2,
      OP_ERASE       = 3'd3,
      OP_READ        = 3'd4,
      OP_CLEAR       = 3'd5,
      OP_FIRST       = 3'd6,
      OP_LAST        = 3'd7
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK   = 2'd0,
      ST_NONE = 2'd1,
      ST_FULL = 2'd2
   } status_type;

   typedef struct packed {
      op_type              op;
      logic [INDEX_W-1:0]  index;
      logic [VALUE_W-1:0]  value;
   } req_type;

   typedef struct packed {
      logic [READ_DATA_W-1:0] read_data;
      logic [COUNT_W-1:0]     count;
      status_type             status;
   } rsp_type;

   // broadcast from the controller to every cell
   typedef struct packed {
      logic                  ins;
      logic                  app;
      logic                  era;
      logic                  rd;
      logic [CMP_W-1:0]      idx;
      logic [CMP_W-1:0]      cnt;
      logic [CMP_W-1:0]      sel;
      logic [DATA_WIDTH-1:0] value;
   } cell_cmd_type;

endpackage

FILE: rtl/core/oaie_cell.sv
// ----------------------------------------------------------------------------
// oaie_cell
// one array slot: loads the new value, takes a neighbor's entry or holds
// ----------------------------------------------------------------------------
module oaie_cell (
   input  logic                          clock,
   input  logic [oaie_pkg::IDX_W-1:0]    pos,
   input  oaie_pkg::cell_cmd_type        cmd,
   input  logic [oaie_pkg::DATA_WIDTH-1:0] left_data,
   input  logic [oaie_pkg::DATA_WIDTH-1:0] right_data,
   output logic [oaie_pkg::DATA_WIDTH-1:0] data,
   output logic [oaie_pkg::DATA_WIDTH-1:0] rd_data
);
   import oaie_pkg::*;

   logic [DATA_WIDTH-1:0] data_ff;
   logic [DATA_WIDTH-1:0] data_in;
   logic [CMP_W-1:0]      pos_ext;

   assign pos_ext = CMP_W'(pos);

   always_comb begin
      data_in = data_ff;
      priority if (cmd.ins) begin
         if (pos_ext == cmd.idx) begin
            data_in = cmd.value;
         end else if (pos_ext > cmd.idx) begin
            data_in = left_data;
         end
      end else if (cmd.app) begin
         if (pos_ext == cmd.cnt) begin
            data_in = cmd.value;
         end
      end else if (cmd.era) begin
         // slots from the erased one upward close the gap
         if (pos_ext >= cmd.idx) begin
            data_in = right_data;
         end
      end else begin
         data_in = data_ff;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data    = data_ff;
   assign rd_data = (cmd.rd && (pos_ext == cmd.sel)) ? data_ff : '0;

endmodule

FILE: rtl/core/ordered_array_insert_erase.sv
// ----------------------------------------------------------------------------
// ordered_array_insert_erase
// fixed-capacity ordered array with append, insert, erase and read
// ----------------------------------------------------------------------------
// The request channel (req_valid, req_stall, req_data) carries one operation
// per transfer: append, remove last, insert, erase, read, clear, first, last.
// Every request produces exactly one response on the rsp_ channel with the
// data read or removed, the entry count after the operation and a status.
// Entries sit in a row of cells; an insert or erase moves every cell above
// the index to its neighbor in the same clock. The response appears in the
// cycle after the request transfer, and a new request is taken every cycle
// while responses are being drained; the single response register is what
// limits throughput to one per cycle.
// When rsp_stall holds a response, req_stall is raised and the pending
// response stays unchanged until it is taken.
// Reset empties the array (count zero) and drops any pending response; the
// entry contents are left as they were and are never read before written.
// ----------------------------------------------------------------------------
module ordered_array_insert_erase (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  oaie_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output oaie_pkg::rsp_type rsp_data
);
   import oaie_pkg::*;

`include "ordered_array_insert_erase_macros.svh"

   logic                  accept;
   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      count_in;
   logic [CNT_W-1:0]      count_next;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   rsp_type               rsp_data_ff;
   rsp_type               rsp_data_in;
   status_type            status;
   cell_cmd_type          cmd;
   logic                  full;
   logic                  empty;
   logic [CMP_W-1:0]      idx_ext;
   logic [CMP_W-1:0]      cnt_ext;
   logic [DATA_WIDTH-1:0] read_word;

   logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
   logic [DATA_WIDTH-1:0] cell_rd   [CAPACITY];

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign full    = (count_ff == CNT_W'(CAPACITY));
   assign empty   = (count_ff == '0);
   assign idx_ext = CMP_W'(req_data.index);
   assign cnt_ext = CMP_W'(count_ff);

   // operation decode and the command broadcast to the cells
   always_comb begin
      status     = ST_OK;
      count_next = count_ff;
      cmd        = '0;
      cmd.idx    = idx_ext;
      cmd.cnt    = cnt_ext;
      cmd.sel    = cnt_ext - CMP_W'(1);
      cmd.value  = DATA_WIDTH'(req_data.value);
      unique case (req_data.op)
         OP_APPEND: begin
            if (full) begin
               status = ST_FULL;
            end else begin
               cmd.app    = 1'b1;
               count_next = count_ff + CNT_W'(1);
            end
         end
         OP_REMOVE_LAST: begin
            if (empty) begin
               status = ST_NONE;
            end else begin
               cmd.rd     = 1'b1;
               count_next = count_ff - CNT_W'(1);
            end
         end
         OP_INSERT: begin
            if (idx_ext > cnt_ext) begin
               status = ST_NONE;
            end else if (full) begin
               status = ST_FULL;
            end else begin
               cmd.ins    = 1'b1;
               count_next = count_ff + CNT_W'(1);
            end
         end
         OP_ERASE: begin
            cmd.sel = idx_ext;
            if (idx_ext >= cnt_ext) begin
               status = ST_NONE;
            end else begin
               cmd.rd     = 1'b1;
               cmd.era    = 1'b1;
               count_next = count_ff - CNT_W'(1);
            end
         end
         OP_READ: begin
            cmd.sel = idx_ext;
            if (idx_ext >= cnt_ext) begin
               status = ST_NONE;
            end else begin
               cmd.rd = 1'b1;
            end
         end
         OP_CLEAR: begin
            count_next = '0;
         end
         OP_FIRST: begin
            cmd.sel = '0;
            if (empty) begin
               status = ST_NONE;
            end else begin
               cmd.rd = 1'b1;
            end
         end
         OP_LAST: begin
            if (empty) begin
               status = ST_NONE;
            end else begin
               cmd.rd = 1'b1;
            end
         end
      endcase
      // cells only move on an accepted transfer
      cmd.ins = cmd.ins && accept;
      cmd.app = cmd.app && accept;
      cmd.era = cmd.era && accept;
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_data;
      logic [DATA_WIDTH-1:0] right_data;

      if (i == 0) begin : g_first
         assign left_data = '0;
      end else begin : g_mid
         assign left_data = cell_data[i-1];
      end
      if (i == CAPACITY - 1) begin : g_top
         assign right_data = cell_data[i];
      end else begin : g_below
         assign right_data = cell_data[i+1];
      end

      oaie_cell u_cell (
         .clock      (clock),
         .pos        (IDX_W'(i)),
         .cmd        (cmd),
         .left_data  (left_data),
         .right_data (right_data),
         .data       (cell_data[i]),
         .rd_data    (cell_rd[i])
      );
   end

   // at most one cell drives a nonzero read word
   always_comb begin
      read_word = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         read_word = read_word | cell_rd[i];
      end
   end

   always_comb begin
      rsp_data_in.read_data = READ_DATA_W'(read_word);
      rsp_data_in.count     = COUNT_W'(count_next);
      rsp_data_in.status    = status;
   end

   always_comb begin
      count_in     = accept ? count_next : count_ff;
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `OAIE_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(CAPACITY), "count above capacity")
   `OAIE_ASSERT_NEXT(a_full_append, clock, reset, accept && (req_data.op == OP_APPEND) && full, rsp_valid_ff && (rsp_data_ff.status == ST_FULL), "append on full array not flagged")
   `OAIE_ASSERT_NEXT(a_fail_keeps_count, clock, reset, accept && (status != ST_OK), $stable(count_ff), "failed operation changed the count")
   `OAIE_ASSERT_NEXT(a_clear_empties, clock, reset, accept && (req_data.op == OP_CLEAR), count_ff == '0, "clear left entries")
   `OAIE_ASSERT_IMPL(a_fail_zero_data, clock, reset, rsp_valid_ff && (rsp_data_ff.status != ST_OK), rsp_data_ff.read_data == '0, "data on a failed response")

endmodule

FILE: sim/ordered_array_insert_erase_checker.sv
// ----------------------------------------------------------------------------
// ordered_array_insert_erase_checker
// watches both channels of the ordered array, predicts and compares responses
// ----------------------------------------------------------------------------
// Each request transfer runs through a behavioral copy of the array. The
// copy yields the response that the block should give, and that response is
// queued. Each response transfer is compared field by field with the oldest
// queued response. Mismatches and unexpected responses are counted and
// handed to the testbench top, along with the queue depth and the fill level.
// ----------------------------------------------------------------------------
module ordered_array_insert_erase_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  oaie_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  oaie_pkg::rsp_type rsp_data,
   output int                mismatches,
   output int                outstanding,
   output int                fill_level,
   output int                checked,
   output int                full_seen,
   output int                none_seen
);
   timeunit 1ns;
   timeprecision 1ps;
   import oaie_pkg::*;

   logic [DATA_WIDTH-1:0] slots [CAPACITY];
   int                    occupancy = 0;
   int                    fail_total = 0;
   int                    rsp_total = 0;
   int                    full_total = 0;
   int                    none_total = 0;
   rsp_type               pending_rsp [$];

   // runs one operation on the shadow array and returns its response
   function automatic rsp_type apply_op(req_type r);
      rsp_type o;
      int      at;
      o = '0;
      o.status = ST_OK;
      at = int'(r.index);
      case (r.op)
         OP_APPEND: begin
            if (occupancy >= CAPACITY) begin
               o.status = ST_FULL;
            end else begin
               slots[occupancy] = r.value;
               occupancy++;
            end
         end
         OP_REMOVE_LAST: begin
            if (occupancy == 0) begin
               o.status = ST_NONE;
            end else begin
               occupancy--;
               o.read_data = slots[occupancy];
            end
         end
         OP_INSERT: begin
            // index past the end wins over full
            if (at > occupancy) begin
               o.status = ST_NONE;
            end else if (occupancy >= CAPACITY) begin
               o.status = ST_FULL;
            end else begin
               for (int k = occupancy; k > at; k--) slots[k] = slots[k-1];
               slots[at] = r.value;
               occupancy++;
            end
         end
         OP_ERASE: begin
            if (at >= occupancy) begin
               o.status = ST_NONE;
            end else begin
               o.read_data = slots[at];
               for (int k = at + 1; k < occupancy; k++) slots[k-1] = slots[k];
               occupancy--;
            end
         end
         OP_READ: begin
            if (at >= occupancy) o.status = ST_NONE;
            else o.read_data = slots[at];
         end
         OP_CLEAR: begin
            occupancy = 0;
         end
         OP_FIRST: begin
            if (occupancy == 0) o.status = ST_NONE;
            else o.read_data = slots[0];
         end
         default: begin
            if (occupancy == 0) o.status = ST_NONE;
            else o.read_data = slots[occupancy-1];
         end
      endcase
      o.count = COUNT_W'(occupancy);
      return o;
   endfunction

   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         occupancy = 0;
         pending_rsp.delete();
      end else begin
         if (req_valid && !req_stall) begin
            pending_rsp.insert(pending_rsp.size(), apply_op(req_data));
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_rsp.size() == 0) begin
               fail_total++;
               if (fail_total <= 10)
                  $display("%0t: unexpected response: data %h count %0d status %0d",
                           $realtime, rsp_data.read_data, rsp_data.count,
                           rsp_data.status);
            end else begin
               want = pending_rsp.pop_front();
               rsp_total++;
               if (want.status == ST_FULL) full_total++;
               if (want.status == ST_NONE) none_total++;
               if (rsp_data.read_data !== want.read_data ||
                   rsp_data.count !== want.count ||
                   rsp_data.status !== want.status) begin
                  fail_total++;
                  if (fail_total <= 10)
                     $display({"%0t: response %0d mismatch: data %h/%h ",
                               "count %0d/%0d status %0d/%0d (exp/act)"},
                              $realtime, rsp_total, want.read_data, rsp_data.read_data,
                              want.count, rsp_data.count, want.status, rsp_data.status);
               end
            end
         end
      end
      mismatches  <= fail_total;
      outstanding <= pending_rsp.size();
      fill_level  <= occupancy;
      checked     <= rsp_total;
      full_seen   <= full_total;
      none_seen   <= none_total;
   end

endmodule

FILE: sim/tb_ordered_array_insert_erase.sv
// ----------------------------------------------------------------------------
// tb_ordered_array_insert_erase
// stimulus and verdict for the ordered array with insert and erase
// ----------------------------------------------------------------------------
// A directed opening covers the empty array, the front, middle and end of the
// array and indexes past the end. Random phases then fill, drain or mix the
// array so that it reaches full and empty many times. Both sides idle in
// random bursts, and once the response side holds off long enough for the
// block to stall its input. The checker does the prediction and comparison.
// ----------------------------------------------------------------------------
module tb_ordered_array_insert_erase;
   timeunit 1ns;
   timeprecision 1ps;
   import oaie_pkg::*;

   localparam int RANDOM_ITEMS = 925;
   localparam int CALM_AFTER   = 800;
   localparam int HOLD_AT      = 300;
   localparam int HOLD_CYCLES  = 200;
   localparam int CYCLE_LIMIT  = 200000;

   typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED} phase_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   int      mismatches;
   int      outstanding;
   int      fill_level;
   int      checked;
   int      full_seen;
   int      none_seen;

   int      transfers_sent = 0;
   int      cycle_count = 0;
   bit      calm = 0;

   ordered_array_insert_erase dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   ordered_array_insert_erase_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .mismatches  (mismatches),
      .outstanding (outstanding),
      .fill_level  (fill_level),
      .checked     (checked),
      .full_seen   (full_seen),
      .none_seen   (none_seen)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // offers one request, waits for its transfer, then maybe idles a while
   task automatic put(op_type op, logic [INDEX_W-1:0] idx, logic [VALUE_W-1:0] val);
      req_type r;
      r.op = op;
      r.index = idx;
      r.value = val;
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      transfers_sent++;
      if (!calm && $urandom_range(0, 99) < 12) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
   endtask

   function automatic op_type pick_op(phase_type ph);
      int unsigned w [8];
      int unsigned roll;
      // weights in op code order: append, remove last, insert, erase,
      // read, clear, first, last
      case (ph)
         PH_FILL:  w = '{45, 2, 40, 3, 5, 0, 2, 3};
         PH_DRAIN: w = '{5, 30, 5, 40, 10, 0, 5, 5};
         default:  w = '{18, 10, 18, 18, 18, 4, 7, 7};
      endcase
      roll = $urandom_range(0, 99);
      for (int k = 0; k < 8; k++) begin
         if (roll < w[k]) return op_type'(k);
         roll -= w[k];
      end
      return OP_LAST;
   endfunction

   // mostly valid positions, some at the edge, some anywhere
   function automatic logic [INDEX_W-1:0] pick_index(int level);
      int          hi;
      int unsigned roll;
      hi = (level > 63) ? 63 : level;
      roll = $urandom_range(0, 99);
      if (roll < 60) return INDEX_W'($urandom_range(0, hi));
      if (roll < 85) return INDEX_W'((hi == 0) ? 0 : $urandom_range(hi - 1, hi));
      return INDEX_W'($urandom_range(0, 63));
   endfunction

   function automatic logic [VALUE_W-1:0] pick_value();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 6) return '0;
      if (roll < 12) return '1;
      return VALUE_W'($urandom());
   endfunction

   // response side: random stall bursts plus one long hold-off
   initial begin
      bit held;
      held = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!held && transfers_sent >= HOLD_AT) begin
            held = 1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (!calm && !reset && $urandom_range(0, 99) < 10) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 15)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d responses still due",
                     cycle_count, outstanding);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin
      phase_type ph;
      int        random_sent;
      int        run_len;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty array: every read and removal has no element
      put(OP_READ, 6'd0, 32'h0);
      put(OP_FIRST, 6'd0, 32'h0);
      put(OP_LAST, 6'd0, 32'h0);
      put(OP_REMOVE_LAST, 6'd0, 32'h0);
      put(OP_ERASE, 6'd0, 32'h0);
      put(OP_INSERT, 6'd1, 32'hDEAD_BEEF);
      // insert at the count acts as append
      put(OP_INSERT, 6'd0, 32'hFFFF_FFFF);
      put(OP_APPEND, 6'd63, 32'h0000_0000);
      put(OP_APPEND, 6'd0, 32'hA5A5_5A5A);
      put(OP_INSERT, 6'd0, 32'h1234_5678);
      put(OP_INSERT, 6'd2, 32'h8000_0001);
      put(OP_INSERT, 6'd5, 32'h7FFF_FFFE);
      put(OP_INSERT, 6'd63, 32'h0F0F_0F0F);
      put(OP_READ, 6'd0, 32'h0);
      put(OP_READ, 6'd5, 32'h0);
      put(OP_READ, 6'd6, 32'h0);
      put(OP_READ, 6'd63, 32'hFFFF_FFFF);
      put(OP_FIRST, 6'd0, 32'h0);
      put(OP_LAST, 6'd0, 32'h0);
      put(OP_ERASE, 6'd2, 32'h0);
      put(OP_ERASE, 6'd0, 32'h0);
      put(OP_ERASE, 6'd2, 32'h0);
      put(OP_ERASE, 6'd63, 32'h0);
      put(OP_REMOVE_LAST, 6'd0, 32'h0);
      put(OP_CLEAR, 6'd0, 32'h0);

      // random phases; the first one is a fill phase
      random_sent = 0;
      ph = PH_FILL;
      while (random_sent < RANDOM_ITEMS) begin
         run_len = $urandom_range(40, 120);
         for (int n = 0; n < run_len && random_sent < RANDOM_ITEMS; n++) begin
            if (random_sent >= CALM_AFTER) calm = 1;
            put(pick_op(ph), pick_index(fill_level), pick_value());
            random_sent++;
         end
         case ($urandom_range(0, 2))
            0:       ph = PH_FILL;
            1:       ph = PH_DRAIN;
            default: ph = PH_MIXED;
         endcase
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("sent %0d requests over fill, drain and mixed phases; %0d responses checked",
               transfers_sent, checked);
      $display("%0d responses reported a full array, %0d reported no such element",
               full_seen, none_seen);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/oaie_pkg.sv
rtl/core/oaie_cell.sv
rtl/core/ordered_array_insert_erase.sv
sim/ordered_array_insert_erase_checker.sv
sim/tb_ordered_array_insert_erase.sv
